/* rtl/spa_pkg.sv */
`default_nettype none

package spa_pkg;

    localparam int MAX_TERMS_DEF = 64;

    localparam int ACTION_W = 2;
    localparam int COEF_W   = 32;
    localparam int EXP_W    = 16;
    localparam int INDEX_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // A token walks the cell chain, one cell per cycle. The live bit stays set
    // until the term has been merged or placed, or until the queried term has
    // been found.
    typedef struct packed {
        logic                     is_query;
        logic                     live;
        logic                     full;
        logic                     placed;
        logic                     found;
        logic [INDEX_W-1:0]       rem;
        logic signed [EXP_W-1:0]  expo;
        logic signed [COEF_W-1:0] coef;
    } tok_t;

    typedef struct packed {
        logic                     term_valid;
        logic signed [COEF_W-1:0] coef;
        logic signed [EXP_W-1:0]  expo;
        logic                     ovf;
    } res_t;

    function automatic logic signed [COEF_W-1:0] sat_add(
        input logic signed [COEF_W-1:0] a,
        input logic signed [COEF_W-1:0] b
    );
        logic signed [COEF_W:0] sum;
        logic signed [COEF_W-1:0] res;
        sum = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        if (sum[COEF_W] != sum[COEF_W-1])
        begin
            res = sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end
        else
        begin
            res = sum[COEF_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/spa_cell.sv */
`default_nettype none

module spa_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clr,
    input  wire logic          tok_in_valid,
    input  wire spa_pkg::tok_t tok_in,
    output logic               tok_out_valid,
    output spa_pkg::tok_t      tok_out
);
    import spa_pkg::*;

    logic                     occ_reg;
    logic                     occ_next;
    logic signed [EXP_W-1:0]  exp_reg;
    logic signed [EXP_W-1:0]  exp_next;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] coef_next;
    logic                     tok_vld_reg;
    tok_t                     tok_reg;
    tok_t                     tok_next;

    always_comb
    begin
        tok_next  = tok_in;
        occ_next  = occ_reg;
        exp_next  = exp_reg;
        coef_next = coef_reg;
        if (tok_in_valid && tok_in.live)
        begin
            if (!tok_in.is_query)
            begin
                if (!occ_reg)
                begin
                    if (!tok_in.full)
                    begin
                        occ_next        = 1'b1;
                        exp_next        = tok_in.expo;
                        coef_next       = tok_in.coef;
                        tok_next.live   = 1'b0;
                        tok_next.placed = 1'b1;
                    end
                end
                else if (exp_reg == tok_in.expo)
                begin
                    coef_next     = sat_add(coef_reg, tok_in.coef);
                    tok_next.live = 1'b0;
                end
                else if ((tok_in.expo > exp_reg) && !tok_in.full)
                begin
                    // The incoming term takes this slot and the old entry moves on.
                    exp_next      = tok_in.expo;
                    coef_next     = tok_in.coef;
                    tok_next.expo = exp_reg;
                    tok_next.coef = coef_reg;
                end
            end
            else if (occ_reg && (coef_reg != '0))
            begin
                if (tok_in.rem == INDEX_W'(1))
                begin
                    tok_next.live  = 1'b0;
                    tok_next.found = 1'b1;
                    tok_next.expo  = exp_reg;
                    tok_next.coef  = coef_reg;
                end
                else
                begin
                    tok_next.rem = tok_in.rem - INDEX_W'(1);
                end
            end
        end
        if (clr)
        begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            occ_reg     <= occ_next;
            tok_vld_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg  <= exp_next;
        coef_reg <= coef_next;
        tok_reg  <= tok_next;
    end

    assign tok_out_valid = tok_vld_reg;
    assign tok_out       = tok_reg;

endmodule

`default_nettype wire

/* rtl/sparse_polynomial_adder.sv */
// Sparse polynomial accumulator built as a sorted chain of MAX_TERMS cells.
// Input channel (in_valid/in_stall) carries an action with a coefficient
// (signed Q15.16), an exponent and a 1-based term index. A transfer happens
// when in_valid is high and in_stall is low. A clear takes effect at once and
// the next item can follow in the next cycle. An add or a query walks the
// cell chain one cell per cycle, and the input stays stalled until its token
// has left the last cell, so the next item is not taken before then. A query
// result is registered onto the output channel as its token leaves the last
// cell; adds and clears give no result. The output channel (out_valid and
// out_stall) holds its result while out_stall is high; a second result
// waits in a skid register, and the input is stalled until that register
// has drained. Reset empties the table, clears the overflow flag and drops
// any result that has not been taken.
`default_nettype none

module sparse_polynomial_adder #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [spa_pkg::ACTION_W-1:0]         action,
    input  wire logic signed [spa_pkg::COEF_W-1:0]    coefficient,
    input  wire logic signed [spa_pkg::EXP_W-1:0]     exponent,
    input  wire logic [spa_pkg::INDEX_W-1:0]          term_index,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      result_valid,
    output logic signed [spa_pkg::COEF_W-1:0]         result_coefficient,
    output logic signed [spa_pkg::EXP_W-1:0]          result_exponent,
    output logic                                      table_overflowed
);
    import spa_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             inj_vld_reg;
    logic             inj_vld_next;
    tok_t             inj_reg;
    tok_t             inj_next;
    logic             clr;
    logic             accept;
    logic             out_vld_reg;
    logic             out_vld_next;
    res_t             out_reg;
    res_t             out_next;
    logic             skid_vld_reg;
    logic             skid_vld_next;
    res_t             skid_reg;
    res_t             skid_next;
    res_t             new_res;
    logic             end_query;

    logic tok_vld [0:MAX_TERMS];
    tok_t tok     [0:MAX_TERMS];

    assign in_stall = busy_reg | skid_vld_reg;
    assign accept   = in_valid & ~in_stall;

    assign tok_vld[0] = inj_vld_reg;
    assign tok[0]     = inj_reg;

    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        spa_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .clr          (clr),
            .tok_in_valid (tok_vld[i]),
            .tok_in       (tok[i]),
            .tok_out_valid(tok_vld[i+1]),
            .tok_out      (tok[i+1])
        );
    end

    assign end_query = tok_vld[MAX_TERMS] & tok[MAX_TERMS].is_query;

    always_comb
    begin
        new_res.term_valid = tok[MAX_TERMS].found;
        new_res.coef       = tok[MAX_TERMS].coef;
        new_res.expo       = tok[MAX_TERMS].expo;
        new_res.ovf        = ovf_reg;
    end

    always_comb
    begin
        busy_next         = busy_reg;
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        clr               = 1'b0;
        inj_vld_next      = 1'b0;
        inj_next.is_query = (action == ACT_QUERY);
        inj_next.live     = !((action == ACT_QUERY) && (term_index == '0));
        inj_next.full     = (count_reg == CNT_W'(MAX_TERMS));
        inj_next.placed   = 1'b0;
        inj_next.found    = 1'b0;
        inj_next.rem      = term_index;
        inj_next.expo     = (action == ACT_QUERY) ? '0 : exponent;
        inj_next.coef     = (action == ACT_QUERY) ? '0 : coefficient;

        if (tok_vld[MAX_TERMS])
        begin
            busy_next = 1'b0;
            if (!tok[MAX_TERMS].is_query)
            begin
                if (tok[MAX_TERMS].placed)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (tok[MAX_TERMS].live)
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        if (accept)
        begin
            unique case (action) inside
                ACT_CLEAR:
                begin
                    clr        = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                ACT_ADD, ACT_QUERY:
                begin
                    inj_vld_next = 1'b1;
                    busy_next    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        if (!out_vld_reg || !out_stall)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
            else if (end_query)
            begin
                out_vld_next = 1'b1;
                out_next     = new_res;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
        else if (end_query)
        begin
            skid_vld_next = 1'b1;
            skid_next     = new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            inj_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            inj_vld_reg  <= inj_vld_next;
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inj_reg  <= inj_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid          = out_vld_reg;
    assign result_valid       = out_reg.term_valid;
    assign result_coefficient = out_reg.coef;
    assign result_exponent    = out_reg.expo;
    assign table_overflowed   = out_reg.ovf;

endmodule

`default_nettype wire

/* rtl/spa_checker.sv */
`default_nettype none

module spa_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [spa_pkg::ACTION_W-1:0]      action,
    input wire logic signed [spa_pkg::COEF_W-1:0] coefficient,
    input wire logic signed [spa_pkg::EXP_W-1:0]  exponent,
    input wire logic [spa_pkg::INDEX_W-1:0]       term_index,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              result_valid,
    input wire logic signed [spa_pkg::COEF_W-1:0] result_coefficient,
    input wire logic signed [spa_pkg::EXP_W-1:0]  result_exponent,
    input wire logic                              table_overflowed
);
    import spa_pkg::*;

    // A stalled transfer keeps its valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // A stalled transfer keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_valid) && $stable(result_coefficient)
            && $stable(result_exponent) && $stable(table_overflowed))
        else $error("result changed while stalled");

    // Queries skip entries whose sum is zero.
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_valid |-> result_coefficient != '0)
        else $error("found term has a zero coefficient");

    // A query that finds no term reports zero fields.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |-> result_coefficient == '0 && result_exponent == '0)
        else $error("missed query reports nonzero fields");

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (.*);

`default_nettype wire

/* test/sparse_polynomial_adder_tb.sv */
`default_nettype none

class term_scoreboard;
    localparam int SLOTS = spa_pkg::MAX_TERMS_DEF;

    logic signed [spa_pkg::EXP_W-1:0]  exps [SLOTS];
    logic signed [spa_pkg::COEF_W-1:0] coefs[SLOTS];
    int unsigned                       used;
    bit                                ovf;
    spa_pkg::res_t                     expected_terms[$];
    int                                errors;

    function new();
        used   = 0;
        ovf    = 1'b0;
        errors = 0;
    endfunction

    function void add_term(logic signed [spa_pkg::COEF_W-1:0] c,
                           logic signed [spa_pkg::EXP_W-1:0] e);
        int unsigned pos;
        int unsigned i;
        longint      sum;
        pos = 0;
        while (pos < used && exps[pos] > e)
            pos++;
        if (pos < used && exps[pos] == e)
        begin
            sum = longint'(coefs[pos]) + longint'(c);
            if (sum > 64'sh7fffffff)
                sum = 64'sh7fffffff;
            if (sum < -64'sh80000000)
                sum = -64'sh80000000;
            coefs[pos] = sum[spa_pkg::COEF_W-1:0];
            return;
        end
        if (used >= SLOTS)
        begin
            ovf = 1'b1;
            return;
        end
        for (i = used; i > pos; i--)
        begin
            exps[i]  = exps[i-1];
            coefs[i] = coefs[i-1];
        end
        exps[pos]  = e;
        coefs[pos] = c;
        used++;
    endfunction

    function void note_input(logic [spa_pkg::ACTION_W-1:0] act,
                             logic signed [spa_pkg::COEF_W-1:0] c,
                             logic signed [spa_pkg::EXP_W-1:0] e,
                             logic [spa_pkg::INDEX_W-1:0] k);
        spa_pkg::res_t want;
        int unsigned   seen;
        int unsigned   i;
        if (act == spa_pkg::ACT_CLEAR)
        begin
            used = 0;
            ovf  = 1'b0;
        end
        else if (act == spa_pkg::ACT_ADD)
        begin
            add_term(c, e);
        end
        else if (act == spa_pkg::ACT_QUERY)
        begin
            want = '0;
            want.ovf = ovf;
            seen = 0;
            if (k != 0)
            begin
                for (i = 0; i < used; i++)
                begin
                    if (coefs[i] != 0)
                    begin
                        seen++;
                        if (seen == k)
                        begin
                            want.term_valid = 1'b1;
                            want.coef       = coefs[i];
                            want.expo       = exps[i];
                            break;
                        end
                    end
                end
            end
            expected_terms.push_back(want);
        end
    endfunction

    function void check_result(logic v, logic signed [spa_pkg::COEF_W-1:0] c,
                               logic signed [spa_pkg::EXP_W-1:0] e, logic o);
        spa_pkg::res_t want;
        if (expected_terms.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result transfer valid=%0b coef=%0d %s",
                         v, c, $sformatf("exp=%0d ovf=%0b", e, o));
            return;
        end
        want = expected_terms.pop_front();
        if (v !== want.term_valid || c !== want.coef || e !== want.expo || o !== want.ovf)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: expected valid=%0b coef=%0d exp=%0d ovf=%0b, %s",
                         want.term_valid, want.coef, want.expo, want.ovf,
                         $sformatf("got valid=%0b coef=%0d exp=%0d ovf=%0b", v, c, e, o));
        end
    endfunction
endclass

module sparse_polynomial_adder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [spa_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int SLOTS       = spa_pkg::MAX_TERMS_DEF;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_TARGET = 1900;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [spa_pkg::ACTION_W-1:0]        action;
    logic signed [spa_pkg::COEF_W-1:0]   coefficient;
    logic signed [spa_pkg::EXP_W-1:0]    exponent;
    logic [spa_pkg::INDEX_W-1:0]         term_index;
    logic                                out_valid;
    logic                                out_stall;
    logic                                result_valid;
    logic signed [spa_pkg::COEF_W-1:0]   result_coefficient;
    logic signed [spa_pkg::EXP_W-1:0]    result_exponent;
    logic                                table_overflowed;

    term_scoreboard board = new();
    int             idle_phase;
    int             sent_items;
    int             cycle_count;

    sparse_polynomial_adder u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .coefficient        (coefficient),
        .exponent           (exponent),
        .term_index         (term_index),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .result_valid       (result_valid),
        .result_coefficient (result_coefficient),
        .result_exponent    (result_exponent),
        .table_overflowed   (table_overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic bit sender_idles();
        case (idle_phase)
            1:       return $urandom_range(0, 99) < 77;
            3:       return $urandom_range(0, 99) < 28;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_phase)
            2:       return $urandom_range(0, 99) < 77;
            3:       return $urandom_range(0, 99) < 28;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [spa_pkg::COEF_W-1:0] rand_coef();
        int v;
        case ($urandom_range(0, 5))
            0:
            begin
                return $urandom;
            end
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 32'sh00000001;
                    3:       return 32'shffffffff;
                    default: return 32'sh00000000;
                endcase
            end
            2:
            begin
                v = int'($urandom_range(0, 65535));
                return $urandom_range(0, 1) ? 32'sh60000000 + v : 32'sha0000000 - v;
            end
            default:
            begin
                v = int'($urandom_range(0, 8)) - 4;
                return v * 16384;
            end
        endcase
    endfunction

    function automatic logic [spa_pkg::INDEX_W-1:0] rand_index();
        if ($urandom_range(0, 9) == 0)
            return spa_pkg::INDEX_W'($urandom_range(0, 127));
        return spa_pkg::INDEX_W'($urandom_range(0, board.used + 1));
    endfunction

    task automatic send_item(input logic [spa_pkg::ACTION_W-1:0] act,
                             input logic signed [spa_pkg::COEF_W-1:0] c,
                             input logic signed [spa_pkg::EXP_W-1:0] e,
                             input logic [spa_pkg::INDEX_W-1:0] k);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        coefficient <= c;
        exponent    <= e;
        term_index  <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(act, c, e, k);
        if (act != ACT_UNUSED)
            sent_items++;
    endtask

    task automatic run_sequence();
        int                              kind;
        int                              n;
        int                              i;
        logic signed [spa_pkg::EXP_W-1:0] base;
        logic signed [spa_pkg::EXP_W-1:0] e;
        kind = $urandom_range(0, 9);
        base = spa_pkg::EXP_W'($urandom);
        if (kind != 7 && kind != 8)
            send_item(spa_pkg::ACT_CLEAR, rand_coef(), spa_pkg::EXP_W'($urandom),
                      rand_index());
        case (kind)
            6:
            begin
                n = $urandom_range(60, 72);
                for (i = 0; i < n; i++)
                    send_item(spa_pkg::ACT_ADD, rand_coef(), spa_pkg::EXP_W'($urandom),
                              rand_index());
            end
            7:
            begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    send_item(spa_pkg::ACTION_W'($urandom_range(0, 3)), $urandom,
                              spa_pkg::EXP_W'($urandom),
                              spa_pkg::INDEX_W'($urandom_range(0, 127)));
            end
            8:
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                begin
                    if (board.used > 0 && $urandom_range(0, 1))
                        e = board.exps[$urandom_range(0, board.used - 1)];
                    else
                        e = base + spa_pkg::EXP_W'($urandom_range(0, 7));
                    send_item(spa_pkg::ACT_ADD, rand_coef(), e, rand_index());
                end
            end
            9:
            begin
                n = $urandom_range(3, 10);
                for (i = 0; i < n; i++)
                    send_item(spa_pkg::ACT_ADD,
                              $urandom_range(0, 1) ? 32'sh7f000000 : 32'sh81000000,
                              base + spa_pkg::EXP_W'($urandom_range(0, 1)), rand_index());
            end
            default:
            begin
                n = $urandom_range(1, 20);
                for (i = 0; i < n; i++)
                    send_item(spa_pkg::ACT_ADD, rand_coef(),
                              base + spa_pkg::EXP_W'($urandom_range(0, 7)), rand_index());
            end
        endcase
        if (kind != 7)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                send_item(spa_pkg::ACT_QUERY, rand_coef(), spa_pkg::EXP_W'($urandom),
                          rand_index());
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_result(result_valid, result_coefficient, result_exponent,
                                   table_overflowed);
            out_stall <= receiver_stalls();
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        out_stall   <= 1'b0;
        action      <= spa_pkg::ACT_CLEAR;
        coefficient <= '0;
        exponent    <= '0;
        term_index  <= '0;
        idle_phase  = 0;
        sent_items  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd0);
        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd1);
        send_item(spa_pkg::ACT_ADD, 32'sh7fffffff, 16'sh7fff, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'sh7fffffff, 16'sh7fff, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'sh80000000, 16'sh8000, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'sh80000000, 16'sh8000, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'sh00010000, 16'sh0000, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'shffff0000, 16'sh0000, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'sh00000000, 16'sh0005, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'sh12345678, 16'shffff, 7'd0);
        for (int k = 0; k <= 4; k++)
            send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, spa_pkg::INDEX_W'(k));
        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd64);
        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd127);
        send_item(ACT_UNUSED, 32'sh5a5a5a5a, 16'sh1234, 7'd1);
        send_item(spa_pkg::ACT_ADD, 32'sh00010000, 16'sh0000, 7'd0);
        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd3);
        send_item(spa_pkg::ACT_CLEAR, 32'shffffffff, 16'shffff, 7'd127);
        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd1);
        send_item(spa_pkg::ACT_ADD, 32'shaaaaaaaa, 16'sh5555, 7'd0);
        send_item(spa_pkg::ACT_ADD, 32'sh55555555, 16'shaaaa, 7'd0);
        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd1);
        send_item(spa_pkg::ACT_QUERY, 32'sh0, 16'sh0, 7'd2);

        for (int p = 0; p < 4; p++)
        begin
            idle_phase = p;
            while (sent_items < 25 + (ITEM_TARGET * (p + 1)) / 4)
                run_sequence();
        end
        in_valid <= 1'b0;

        while (board.expected_terms.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);
        if (board.expected_terms.size() != 0)
            board.errors++;

        if (board.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
